// File: rtl/sdu_pkg.sv
// ----------------------------------------------------------------------------
// sdu_pkg
// Types and constants shared by the program dump unpacker modules.
// ----------------------------------------------------------------------------
package sdu_pkg;

  localparam int COUNT_BITS_DEFAULT = 12;
  localparam int OUT_COUNT_W        = 12;
  localparam int CFG_DATA_W         = 12;
  localparam int CFG_INDEX_W        = 1;
  localparam int MFR_W              = 7;

  localparam logic [7:0] SYX_START        = 8'hF0;
  localparam logic [7:0] SYX_END          = 8'hF7;
  localparam logic [7:0] CMD_PROGRAM_DATA = 8'h02;

  localparam logic [2:0] HDR_POS_START   = 3'd0;
  localparam logic [2:0] HDR_POS_MFR     = 3'd1;
  localparam logic [2:0] HDR_POS_DEVICE  = 3'd2;
  localparam logic [2:0] HDR_POS_COMMAND = 3'd3;
  localparam logic [2:0] HDR_POS_BANK    = 3'd4;
  localparam logic [2:0] HDR_POS_PROGRAM = 3'd5;
  localparam logic [2:0] HDR_LEN         = 3'd6;

  localparam logic [2:0] GROUP_LAST = 3'd7;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MANUFACTURER = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MIN_BYTES    = 1'b1;

  localparam logic [MFR_W-1:0]       MFR_RESET       = 7'd1;
  localparam logic [CFG_DATA_W-1:0]  MIN_BYTES_RESET = 12'd1024;

  typedef enum logic [1:0] {
    VERDICT_ACCEPTED  = 2'd0,
    VERDICT_BAD_HDR   = 2'd1,
    VERDICT_BAD_END   = 2'd2,
    VERDICT_TOO_SHORT = 2'd3
  } sdu_verdict_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_VERDICT = 1'b1
  } sdu_kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } sdu_in_t;

  typedef struct packed {
    sdu_kind_t              result_kind;
    logic [7:0]             data_byte;
    sdu_verdict_t           verdict;
    logic [7:0]             device_id;
    logic [7:0]             bank;
    logic [7:0]             program_number;
    logic [OUT_COUNT_W-1:0] byte_count;
  } sdu_out_t;

  typedef struct packed {
    logic [MFR_W-1:0]      manufacturer_id;
    logic [CFG_DATA_W-1:0] min_data_bytes;
  } sdu_cfg_t;

endpackage

// File: rtl/sysex_program_dump_unpacker.sv
// ----------------------------------------------------------------------------
// sysex_program_dump_unpacker
// Unpacks a program dump system-exclusive message into data bytes and a
// final verdict with the header fields and the data byte count.
// ----------------------------------------------------------------------------
// The block takes one message byte transaction in every clock cycle while
// in_stall is low, and presents its result through an input register and a
// result register around a single pass of logic that updates the message
// state. Header bytes and the high-bit byte of each group give no result;
// each data byte gives one, and the final byte gives a verdict. A stall on
// the result side holds the result register and then the input register, so
// a stalled consumer loses nothing. Configuration is to be written by the
// user only while no message byte is in flight; the block does not enforce it.
module sysex_program_dump_unpacker #(
  parameter int COUNT_BITS = sdu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sdu_pkg::sdu_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sdu_pkg::sdu_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [sdu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sdu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sdu_pkg::sdu_cfg_t cfg;
  logic              hold_valid;
  sdu_pkg::sdu_in_t  hold_data;
  logic              hold_take;

  sdu_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sdu_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .hold_take  (hold_take)
  );

  sdu_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .hold_take  (hold_take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: rtl/sdu_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdu_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module sdu_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sdu_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sdu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output sdu_pkg::sdu_cfg_t                cfg
);

  sdu_pkg::sdu_cfg_t cfg_r;
  sdu_pkg::sdu_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        sdu_pkg::CFG_IDX_MANUFACTURER: begin
          cfg_nxt.manufacturer_id = cfg_data[sdu_pkg::MFR_W-1:0];
        end
        sdu_pkg::CFG_IDX_MIN_BYTES: begin
          cfg_nxt.min_data_bytes = cfg_data;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manufacturer_id <= sdu_pkg::MFR_RESET;
      cfg_r.min_data_bytes  <= sdu_pkg::MIN_BYTES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/sdu_in_reg.sv
// ----------------------------------------------------------------------------
// sdu_in_reg
// Input register stage that holds one byte transaction for the core.
// ----------------------------------------------------------------------------
module sdu_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sdu_pkg::sdu_in_t  in_data,
  output logic              hold_valid,
  output sdu_pkg::sdu_in_t  hold_data,
  input  logic              hold_take
);

  logic             valid_r;
  logic             valid_nxt;
  sdu_pkg::sdu_in_t data_r;
  logic             load;

  assign in_stall = valid_r && !hold_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

// File: rtl/sdu_core.sv
// ----------------------------------------------------------------------------
// sdu_core
// Message state, header check, bit restore and the result register.
// ----------------------------------------------------------------------------
module sdu_core #(
  parameter int COUNT_BITS = sdu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sdu_pkg::sdu_cfg_t cfg,
  input  logic              hold_valid,
  input  sdu_pkg::sdu_in_t  hold_data,
  output logic              hold_take,
  output logic              out_valid,
  input  logic              out_stall,
  output sdu_pkg::sdu_out_t out_data
);

  localparam int WIDE = (COUNT_BITS > sdu_pkg::OUT_COUNT_W) ? COUNT_BITS
                                                            : sdu_pkg::OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};

  logic [2:0]            hdr_pos_r,   hdr_pos_nxt;
  logic [2:0]            grp_pos_r,   grp_pos_nxt;
  logic [6:0]            high_bits_r, high_bits_nxt;
  logic                  hdr_ok_r,    hdr_ok_nxt;
  logic [7:0]            device_r,    device_nxt;
  logic [7:0]            bank_r,      bank_nxt;
  logic [7:0]            program_r,   program_nxt;
  logic [COUNT_BITS-1:0] count_r,     count_nxt;

  logic              out_valid_r, out_valid_nxt;
  sdu_pkg::sdu_out_t out_r,       out_nxt;

  logic              consume;
  logic              produce;
  logic [7:0]        b;
  logic [2:0]        bit_idx;
  logic [WIDE-1:0]   count_wide;
  logic [WIDE-1:0]   count_nxt_wide;
  logic [WIDE-1:0]   min_wide;

  assign hold_take = !out_valid_r || !out_stall;
  assign consume   = hold_valid && hold_take;
  assign b         = hold_data.rx_byte;
  assign bit_idx   = grp_pos_r - 3'd1;

  assign count_wide     = WIDE'(count_r);
  assign min_wide       = WIDE'(cfg.min_data_bytes);

  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    grp_pos_nxt    = grp_pos_r;
    high_bits_nxt  = high_bits_r;
    hdr_ok_nxt     = hdr_ok_r;
    device_nxt     = device_r;
    bank_nxt       = bank_r;
    program_nxt    = program_r;
    count_nxt      = count_r;
    count_nxt_wide = count_wide;
    produce        = 1'b0;

    out_nxt                = out_r;
    out_nxt.result_kind    = sdu_pkg::KIND_DATA;
    out_nxt.data_byte      = 8'd0;
    out_nxt.verdict        = sdu_pkg::VERDICT_ACCEPTED;
    out_nxt.device_id      = device_r;
    out_nxt.bank           = bank_r;
    out_nxt.program_number = program_r;
    out_nxt.byte_count     = count_wide[sdu_pkg::OUT_COUNT_W-1:0];

    if (consume) begin
      if (hold_data.last_byte) begin
        produce             = 1'b1;
        out_nxt.result_kind = sdu_pkg::KIND_VERDICT;
        if ((hdr_pos_r < sdu_pkg::HDR_LEN) || !hdr_ok_r) begin
          out_nxt.verdict = sdu_pkg::VERDICT_BAD_HDR;
        end else if (b != sdu_pkg::SYX_END) begin
          out_nxt.verdict = sdu_pkg::VERDICT_BAD_END;
        end else if (count_wide < min_wide) begin
          out_nxt.verdict = sdu_pkg::VERDICT_TOO_SHORT;
        end else begin
          out_nxt.verdict = sdu_pkg::VERDICT_ACCEPTED;
        end
        hdr_pos_nxt   = 3'd0;
        grp_pos_nxt   = 3'd0;
        high_bits_nxt = 7'd0;
        hdr_ok_nxt    = 1'b1;
        device_nxt    = 8'd0;
        bank_nxt      = 8'd0;
        program_nxt   = 8'd0;
        count_nxt     = '0;
      end else if (hdr_pos_r < sdu_pkg::HDR_LEN) begin
        case (hdr_pos_r)
          sdu_pkg::HDR_POS_START: begin
            if (b != sdu_pkg::SYX_START) hdr_ok_nxt = 1'b0;
          end
          sdu_pkg::HDR_POS_MFR: begin
            if (b != {1'b0, cfg.manufacturer_id}) hdr_ok_nxt = 1'b0;
          end
          sdu_pkg::HDR_POS_DEVICE: begin
            device_nxt = b;
          end
          sdu_pkg::HDR_POS_COMMAND: begin
            if (b != sdu_pkg::CMD_PROGRAM_DATA) hdr_ok_nxt = 1'b0;
          end
          sdu_pkg::HDR_POS_BANK: begin
            bank_nxt = b;
          end
          default: begin
            program_nxt = b;
          end
        endcase
        hdr_pos_nxt = hdr_pos_r + 3'd1;
      end else if (grp_pos_r == 3'd0) begin
        high_bits_nxt = b[6:0];
        grp_pos_nxt   = 3'd1;
      end else begin
        produce     = 1'b1;
        grp_pos_nxt = (grp_pos_r == sdu_pkg::GROUP_LAST) ? 3'd0 : grp_pos_r + 3'd1;
        if (count_r != MAX_COUNT) begin
          count_nxt = count_r + 1'b1;
        end
        count_nxt_wide     = WIDE'(count_nxt);
        out_nxt.data_byte  = {b[7] | high_bits_r[bit_idx], b[6:0]};
        out_nxt.byte_count = count_nxt_wide[sdu_pkg::OUT_COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (hold_take) begin
      out_valid_nxt = produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r   <= 3'd0;
      grp_pos_r   <= 3'd0;
      high_bits_r <= 7'd0;
      hdr_ok_r    <= 1'b1;
      device_r    <= 8'd0;
      bank_r      <= 8'd0;
      program_r   <= 8'd0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hdr_pos_r   <= hdr_pos_nxt;
      grp_pos_r   <= grp_pos_nxt;
      high_bits_r <= high_bits_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      device_r    <= device_nxt;
      bank_r      <= bank_nxt;
      program_r   <= program_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sim/sysex_program_dump_unpacker_test.sv
// ----------------------------------------------------------------------------
// sysex_program_dump_unpacker_test
// Self-checking bench for the program dump unpacker. A short directed table of
// message bytes runs first, then random messages, mostly well formed with
// random content, under several register settings. Every accepted byte goes
// through a behavioral copy of the unpacker, and each result transaction is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module sysex_program_dump_unpacker_test;
  import sdu_pkg::*;

  localparam int COUNT_BITS     = COUNT_BITS_DEFAULT;
  localparam int DRAIN_CYCLES   = 8;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASE_ITEMS    = 125;
  localparam int NUM_PHASES     = 8;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t               op;
    logic [7:0]            rx;
    logic                  last;
    logic                  fixed;
    sdu_out_t              res;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
  } dir_row_t;

  typedef enum int {
    MSG_GOOD, MSG_BAD_START, MSG_BAD_MFR, MSG_BAD_CMD, MSG_SHORT, MSG_BAD_END, MSG_NOISE
  } msg_kind_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  sdu_in_t                in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  sdu_out_t               out_data;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic     in_fixed = 1'b0;
  sdu_out_t in_fixed_res = '0;

  logic [2:0]            hdr_pos = '0;
  logic [2:0]            grp_pos = '0;
  logic [6:0]            hi_bits = '0;
  logic                  hdr_ok = 1'b1;
  logic [7:0]            held_dev = '0;
  logic [7:0]            held_bank = '0;
  logic [7:0]            held_prog = '0;
  logic [COUNT_BITS-1:0] unpacked = '0;
  logic [MFR_W-1:0]      mfr_setting = MFR_RESET;
  logic [CFG_DATA_W-1:0] min_setting = MIN_BYTES_RESET;

  sdu_out_t    owed_unpacks[$];
  int          mismatches = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;

  sysex_program_dump_unpacker #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void unpack_step(input sdu_in_t item, output logic emits,
                                      output sdu_out_t res);
    logic hi;
    emits = 1'b0;
    res = '0;
    if (item.last_byte) begin
      res.result_kind = KIND_VERDICT;
      if (hdr_pos < HDR_LEN || !hdr_ok) begin
        res.verdict = VERDICT_BAD_HDR;
      end else if (item.rx_byte != SYX_END) begin
        res.verdict = VERDICT_BAD_END;
      end else if (int'(unpacked) < int'(min_setting)) begin
        res.verdict = VERDICT_TOO_SHORT;
      end else begin
        res.verdict = VERDICT_ACCEPTED;
      end
      res.device_id = held_dev;
      res.bank = held_bank;
      res.program_number = held_prog;
      res.byte_count = OUT_COUNT_W'(unpacked);
      emits = 1'b1;
      hdr_pos = '0;
      grp_pos = '0;
      hi_bits = '0;
      hdr_ok = 1'b1;
      held_dev = '0;
      held_bank = '0;
      held_prog = '0;
      unpacked = '0;
    end else if (hdr_pos < HDR_LEN) begin
      case (hdr_pos)
        HDR_POS_START: begin
          if (item.rx_byte != SYX_START) hdr_ok = 1'b0;
        end
        HDR_POS_MFR: begin
          if (item.rx_byte != {1'b0, mfr_setting}) hdr_ok = 1'b0;
        end
        HDR_POS_DEVICE: held_dev = item.rx_byte;
        HDR_POS_COMMAND: begin
          if (item.rx_byte != CMD_PROGRAM_DATA) hdr_ok = 1'b0;
        end
        HDR_POS_BANK: held_bank = item.rx_byte;
        default: held_prog = item.rx_byte;
      endcase
      hdr_pos = hdr_pos + 3'd1;
    end else if (grp_pos == 3'd0) begin
      hi_bits = item.rx_byte[6:0];
      grp_pos = 3'd1;
    end else begin
      hi = hi_bits[grp_pos - 3'd1];
      grp_pos = (grp_pos == GROUP_LAST) ? 3'd0 : grp_pos + 3'd1;
      if (unpacked != '1) unpacked = unpacked + 1'b1;
      res.result_kind = KIND_DATA;
      res.data_byte = item.rx_byte | {hi, 7'b0};
      res.verdict = VERDICT_ACCEPTED;
      res.device_id = held_dev;
      res.bank = held_bank;
      res.program_number = held_prog;
      res.byte_count = OUT_COUNT_W'(unpacked);
      emits = 1'b1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    logic     emits;
    sdu_out_t res;
    sdu_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        unpack_step(in_data, emits, res);
        if (in_fixed) begin
          owed_unpacks = {owed_unpacks, in_fixed_res};
        end else if (emits) begin
          owed_unpacks = {owed_unpacks, res};
        end
      end
      if (out_valid && !out_stall) begin
        if (owed_unpacks.size() == 0) begin
          $error("result transaction with nothing expected: 0x%0h", out_data);
          mismatches++;
        end else begin
          want = owed_unpacks.pop_front();
          compare_field("result_kind", want.result_kind, out_data.result_kind);
          compare_field("data_byte", want.data_byte, out_data.data_byte);
          compare_field("verdict", want.verdict, out_data.verdict);
          compare_field("device_id", want.device_id, out_data.device_id);
          compare_field("bank", want.bank, out_data.bank);
          compare_field("program_number", want.program_number, out_data.program_number);
          compare_field("byte_count", want.byte_count, out_data.byte_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_phase_left = $urandom_range(16, 256);
    end
    stall_phase_left--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] rx, input logic last,
                           input logic fixed = 1'b0, input sdu_out_t res = '0);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
        burst_left = $urandom_range(64, 256);
      end else begin
        gap = $urandom_range(0, 8);
        burst_left = $urandom_range(1, 16);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{rx_byte: rx, last_byte: last};
    in_fixed <= fixed;
    in_fixed_res <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_unpacks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == CFG_IDX_MANUFACTURER) begin
      mfr_setting = val[MFR_W-1:0];
    end else begin
      min_setting = val;
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_message(input msg_kind_t kind, input int packed_len);
    logic [7:0] hdr [6];
    logic [7:0] end_byte;
    int         hdr_len;
    hdr[0] = SYX_START;
    hdr[1] = {1'b0, mfr_setting};
    hdr[2] = 8'($urandom_range(0, 255));
    hdr[3] = CMD_PROGRAM_DATA;
    hdr[4] = 8'($urandom_range(0, 255));
    hdr[5] = 8'($urandom_range(0, 255));
    hdr_len = int'(HDR_LEN);
    end_byte = SYX_END;
    case (kind)
      MSG_BAD_START: hdr[0] ^= 8'(1 << $urandom_range(0, 7));
      MSG_BAD_MFR: hdr[1] ^= 8'(1 << $urandom_range(0, 7));
      MSG_BAD_CMD: hdr[3] ^= 8'(1 << $urandom_range(0, 7));
      MSG_SHORT: hdr_len = $urandom_range(0, 5);
      MSG_BAD_END: begin
        end_byte = 8'($urandom_range(0, 255));
        if (end_byte == SYX_END) end_byte = ~SYX_END;
      end
      MSG_NOISE: begin
        foreach (hdr[k]) hdr[k] = 8'($urandom_range(0, 255));
        end_byte = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    for (int k = 0; k < hdr_len; k++) send_byte(hdr[k], 1'b0);
    if (hdr_len == int'(HDR_LEN)) begin
      for (int k = 0; k < packed_len; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    send_byte(end_byte, 1'b1);
  endtask

  function automatic dir_row_t byte_row(input logic [7:0] rx, input logic last);
    dir_row_t r;
    r.op = ROW_BYTE;
    r.rx = rx;
    r.last = last;
    r.fixed = 1'b0;
    r.res = '0;
    r.idx = '0;
    r.val = '0;
    return r;
  endfunction

  function automatic dir_row_t check_row(input logic [7:0] rx, input logic last,
                                         input sdu_out_t res);
    dir_row_t r;
    r = byte_row(rx, last);
    r.fixed = 1'b1;
    r.res = res;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = byte_row(8'h00, 1'b0);
    r.op = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  initial begin
    dir_row_t              rows[$];
    msg_kind_t             kind;
    logic [MFR_W-1:0]      mfr;
    logic [CFG_DATA_W-1:0] min_bytes;
    int                    phase_end;

    // A lone final byte is a short message, even though it is not 0xF7.
    rows = {rows, check_row(8'hF0, 1'b1,
        '{KIND_VERDICT, 8'h00, VERDICT_BAD_HDR, 8'h00, 8'h00, 8'h00, 12'd0})};
    rows = {rows, byte_row(8'hF0, 1'b0)};
    rows = {rows, byte_row(8'h01, 1'b0)};
    rows = {rows, byte_row(8'hFF, 1'b0)};
    rows = {rows, byte_row(8'h02, 1'b0)};
    rows = {rows, byte_row(8'h00, 1'b0)};
    rows = {rows, byte_row(8'h80, 1'b0)};
    rows = {rows, byte_row(8'h7F, 1'b0)};
    rows = {rows, check_row(8'h00, 1'b0,
        '{KIND_DATA, 8'h80, VERDICT_ACCEPTED, 8'hFF, 8'h00, 8'h80, 12'd1})};
    rows = {rows, check_row(SYX_END, 1'b1,
        '{KIND_VERDICT, 8'h00, VERDICT_TOO_SHORT, 8'hFF, 8'h00, 8'h80, 12'd1})};
    rows = {rows, cfg_row(CFG_IDX_MIN_BYTES, 12'd0)};
    rows = {rows, cfg_row(CFG_IDX_MANUFACTURER, 12'h07F)};
    rows = {rows, byte_row(8'hF0, 1'b0)};
    rows = {rows, byte_row(8'h7F, 1'b0)};
    rows = {rows, byte_row(8'h00, 1'b0)};
    rows = {rows, byte_row(8'h02, 1'b0)};
    rows = {rows, byte_row(8'hFF, 1'b0)};
    rows = {rows, byte_row(8'h7F, 1'b0)};
    rows = {rows, check_row(SYX_END, 1'b1,
        '{KIND_VERDICT, 8'h00, VERDICT_ACCEPTED, 8'h00, 8'hFF, 8'h7F, 12'd0})};
    // The manufacturer byte 0xFF must not match the register value 0x7F. Data
    // is still unpacked, and the bad header outranks the bad end byte.
    rows = {rows, byte_row(8'hF0, 1'b0)};
    rows = {rows, byte_row(8'hFF, 1'b0)};
    rows = {rows, byte_row(8'h01, 1'b0)};
    rows = {rows, byte_row(8'h02, 1'b0)};
    rows = {rows, byte_row(8'h02, 1'b0)};
    rows = {rows, byte_row(8'h03, 1'b0)};
    rows = {rows, byte_row(8'h01, 1'b0)};
    rows = {rows, byte_row(8'hFF, 1'b0)};
    rows = {rows, check_row(8'h00, 1'b1,
        '{KIND_VERDICT, 8'h00, VERDICT_BAD_HDR, 8'h01, 8'h02, 8'h03, 12'd1})};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].op == ROW_CFG) begin
        drain();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_byte(rows[i].rx, rows[i].last, rows[i].fixed, rows[i].res);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase % 4)
        0: min_bytes = 12'd0;
        1: min_bytes = 12'($urandom_range(0, 15));
        2: min_bytes = 12'($urandom_range(0, 60));
        default: min_bytes = 12'hFFF;
      endcase
      if (phase == 0) begin
        mfr = 7'h00;
      end else if (phase == 1) begin
        mfr = 7'h7F;
      end else begin
        mfr = 7'($urandom_range(0, 127));
      end
      drain();
      write_reg(CFG_IDX_MANUFACTURER, {5'($urandom_range(0, 31)), mfr});
      write_reg(CFG_IDX_MIN_BYTES, min_bytes);
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 99) < 75) begin
          kind = MSG_GOOD;
        end else begin
          kind = msg_kind_t'($urandom_range(int'(MSG_BAD_START), int'(MSG_NOISE)));
        end
        send_message(kind, $urandom_range(0, 40));
      end
    end

    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
